>>> rtl/core/sfla_pkg.sv
`default_nettype none
package sfla_pkg;

  // word and pointer geometry
  localparam int WORD_W = 17;
  localparam int BIN_W = 4;
  localparam int BIN_COUNT = 12;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BIN_COUNT - 1);
  localparam logic [WORD_W-1:0] NIL = {WORD_W{1'b1}};
  localparam int HDR = 24;
  localparam int FTR = 8;
  localparam int OVH = HDR + FTR;
  localparam int ALIGN_M1 = 15;

  // size class limits
  localparam logic [WORD_W-1:0] CLS_SMALL = WORD_W'(128);
  localparam logic [WORD_W-1:0] CLS_256 = WORD_W'(256);
  localparam logic [WORD_W-1:0] CLS_512 = WORD_W'(512);
  localparam logic [WORD_W-1:0] CLS_1K = WORD_W'(1024);
  localparam logic [WORD_W-1:0] CLS_MIN = WORD_W'(16);

  // datapath micro-operations
  typedef enum logic [5:0] {
    OP_NONE,
    OP_LATCH,
    OP_SETUP0, OP_SETUP1, OP_SETUP2, OP_SETUP3,
    OP_NEED, OP_HEAD, OP_NEXTBIN,
    OP_FF_RD, OP_FOUND, OP_FF_NX, OP_FF_ADV,
    OP_RM0, OP_RM1, OP_RM2, OP_RM3, OP_RM4, OP_RM5,
    OP_IN0, OP_IN1, OP_IN2,
    OP_AL_WHOLE, OP_SP0, OP_SP1, OP_SP2, OP_SP3, OP_AL_OK,
    OP_FR_INIT, OP_WK_RD, OP_WK_ADV, OP_WK_HIT,
    OP_RL_RD, OP_RL_TAKE, OP_RL_MRG, OP_RL_FTR, OP_RL_MARK,
    OP_LF_RD, OP_LF_RD2, OP_LF_TAKE, OP_LF_MRG, OP_LF_FTR,
    OP_FR_INS, OP_FR_OK
  } op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic mode;
    logic req_zero;
    logic ready;
    logic free_bad;
    logic cur_nil;
    logic bin_last;
    logic fit;
    logic p_end;
    logic p_hit;
    logic q_free;
    logic split;
    logic right_in;
    logic h_zero;
  } stat_t;

  // size class of a block size
  function automatic logic [BIN_W-1:0] bin_of(input logic [WORD_W-1:0] s);
    logic [BIN_W-1:0] b;
    if (s <= CLS_SMALL) begin
      if (s < CLS_MIN) b = '0;
      else b = BIN_W'(s >> 4) - BIN_W'(1);
    end else if (s <= CLS_256) begin
      b = BIN_W'(8);
    end else if (s <= CLS_512) begin
      b = BIN_W'(9);
    end else if (s <= CLS_1K) begin
      b = BIN_W'(10);
    end else begin
      b = LAST_BIN;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/sfla_ram.sv
`default_nettype none
module sfla_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/sfla_dp.sv
`default_nettype none
module sfla_dp
  import sfla_pkg::*;
#(
  parameter int HEAP_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire op_t         op,
  input  wire logic        in_mode,
  input  wire logic [15:0] in_request_size,
  input  wire logic [15:0] in_block_address,
  output stat_t            stat,
  output logic [15:0]      res_addr,
  output logic             res_ok
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int CW = ((AW > WORD_W) ? AW : WORD_W) + 2;
  localparam int DEPTH = HEAP_BYTES / 8;
  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
  localparam logic [WORD_W-1:0] INIT_SZ = WORD_W'(HEAP_BYTES - OVH);

  logic                  ready_r;
  logic [WORD_W-1:0]     heads_r [BIN_COUNT];
  logic                  mode_r;
  logic [15:0]           req_r, addr_r;
  logic [WORD_W-1:0]     need_r, cur_r, h_r, t_r, tsz_r, fsz_r, sz_r;
  logic [WORD_W-1:0]     nx_r, pv_r, hd_r, nb_r, rest_r, lt_r;
  logic [BIN_W-1:0]      bin_r;
  logic [CW-1:0]         p_r;
  logic [15:0]           res_addr_r;
  logic                  res_ok_r;

  logic                  we;
  logic [CW-1:0]         wb, rb;
  logic [WORD_W-1:0]     wd, q, q_sz;
  logic [WORD_W-1:0]     need_c, rest_c, nb_c, rgrow_c, lgrow_c;
  logic [CW-1:0]         right_c;

  assign q_sz = {q[WORD_W-1:1], 1'b0};
  assign need_c = (WORD_W'(req_r) + WORD_W'(ALIGN_M1)) & ~WORD_W'(ALIGN_M1);
  assign rest_c = fsz_r - need_r - WORD_W'(OVH);
  assign nb_c = h_r + WORD_W'(OVH) + need_r;
  assign right_c = CW'(h_r) + CW'(OVH) + CW'(sz_r);
  assign rgrow_c = sz_r + WORD_W'(OVH) + tsz_r;
  assign lgrow_c = tsz_r + WORD_W'(OVH) + sz_r;

  // heap word store
  sfla_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (wb[AW-1:3]),
    .wdata (wd),
    .raddr (rb[AW-1:3]),
    .rdata (q)
  );

  // memory port drive per operation
  always_comb begin
    we = 1'b0;
    wb = '0;
    wd = '0;
    rb = '0;
    case (op)
      OP_SETUP0:  begin we = 1'b1; wb = '0; wd = INIT_SZ | WORD_W'(1); end
      OP_SETUP1:  begin we = 1'b1; wb = HEAP_C - CW'(FTR); wd = '0; end
      OP_SETUP2:  begin we = 1'b1; wb = CW'(8); wd = NIL; end
      OP_SETUP3:  begin we = 1'b1; wb = CW'(16); wd = NIL; end
      OP_FF_RD:   rb = CW'(cur_r);
      OP_FF_NX:   rb = CW'(cur_r) + CW'(8);
      OP_RM0:     rb = CW'(t_r) + CW'(8);
      OP_RM1:     rb = CW'(t_r) + CW'(16);
      OP_RM2:     begin we = (q != NIL); wb = CW'(q) + CW'(8); wd = nx_r; end
      OP_RM3:     begin we = (nx_r != NIL); wb = CW'(nx_r) + CW'(16); wd = pv_r; end
      OP_RM4:     begin we = 1'b1; wb = CW'(t_r) + CW'(8); wd = NIL; end
      OP_RM5:     begin we = 1'b1; wb = CW'(t_r) + CW'(16); wd = NIL; end
      OP_IN0:     begin we = 1'b1; wb = CW'(t_r) + CW'(8); wd = heads_r[bin_r]; end
      OP_IN1:     begin we = 1'b1; wb = CW'(t_r) + CW'(16); wd = NIL; end
      OP_IN2:     begin we = (hd_r != NIL); wb = CW'(hd_r) + CW'(16); wd = t_r; end
      OP_AL_WHOLE: begin we = 1'b1; wb = CW'(h_r); wd = fsz_r; end
      OP_SP0:     begin we = 1'b1; wb = CW'(nb_c); wd = rest_c | WORD_W'(1); end
      OP_SP1:     begin we = 1'b1; wb = CW'(h_r) + CW'(HDR) + CW'(need_r); wd = h_r; end
      OP_SP2:     begin we = 1'b1; wb = CW'(nb_r) + CW'(HDR) + CW'(rest_r); wd = nb_r; end
      OP_SP3:     begin we = 1'b1; wb = CW'(h_r); wd = need_r; end
      OP_WK_RD:   rb = p_r;
      OP_RL_RD:   rb = right_c;
      OP_RL_MRG:  begin we = 1'b1; wb = CW'(h_r); wd = rgrow_c | WORD_W'(1); end
      OP_RL_FTR:  begin we = 1'b1; wb = CW'(h_r) + CW'(HDR) + CW'(sz_r); wd = h_r; end
      OP_RL_MARK: begin we = 1'b1; wb = CW'(h_r); wd = sz_r | WORD_W'(1); end
      OP_LF_RD:   rb = CW'(h_r) - CW'(FTR);
      OP_LF_RD2:  rb = CW'(q);
      OP_LF_MRG:  begin we = 1'b1; wb = CW'(lt_r); wd = lgrow_c | WORD_W'(1); end
      OP_LF_FTR:  begin we = 1'b1; wb = CW'(lt_r) + CW'(HDR) + CW'(sz_r); wd = lt_r; end
      default:    we = 1'b0;
    endcase
  end

  // bin heads and heap set-up flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      for (int i = 0; i < BIN_COUNT; i++) heads_r[i] <= NIL;
    end else begin
      case (op)
        OP_SETUP3: begin
          heads_r[LAST_BIN] <= '0;
          ready_r <= 1'b1;
        end
        OP_RM2: if (q == NIL) heads_r[bin_r] <= nx_r;
        OP_IN2: heads_r[bin_r] <= t_r;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        mode_r <= in_mode;
        req_r <= in_request_size;
        addr_r <= in_block_address;
        res_addr_r <= '0;
        res_ok_r <= 1'b0;
      end
      OP_NEED:    begin need_r <= need_c; bin_r <= bin_of(need_c); end
      OP_HEAD:    cur_r <= heads_r[bin_r];
      OP_NEXTBIN: bin_r <= bin_r + BIN_W'(1);
      OP_FOUND: begin
        h_r <= cur_r;
        t_r <= cur_r;
        tsz_r <= q_sz;
        fsz_r <= q_sz;
        bin_r <= bin_of(q_sz);
      end
      OP_FF_ADV:  cur_r <= q;
      OP_RM1:     nx_r <= q;
      OP_RM2:     pv_r <= q;
      OP_IN0:     hd_r <= heads_r[bin_r];
      OP_AL_OK: begin
        res_addr_r <= 16'(h_r + WORD_W'(HDR));
        res_ok_r <= 1'b1;
      end
      OP_SP0:     begin rest_r <= rest_c; nb_r <= nb_c; end
      OP_SP3:     begin t_r <= nb_r; tsz_r <= rest_r; bin_r <= bin_of(rest_r); end
      OP_FR_INIT: begin h_r <= WORD_W'(addr_r) - WORD_W'(HDR); p_r <= '0; end
      OP_WK_ADV:  p_r <= p_r + CW'(q_sz) + CW'(OVH);
      OP_WK_HIT:  sz_r <= q_sz;
      OP_RL_TAKE: begin t_r <= WORD_W'(right_c); tsz_r <= q_sz; bin_r <= bin_of(q_sz); end
      OP_RL_MRG:  sz_r <= rgrow_c;
      OP_LF_RD2:  lt_r <= q;
      OP_LF_TAKE: begin t_r <= lt_r; tsz_r <= q_sz; bin_r <= bin_of(q_sz); end
      OP_LF_MRG:  sz_r <= lgrow_c;
      OP_LF_FTR:  h_r <= lt_r;
      OP_FR_INS:  begin t_r <= h_r; tsz_r <= sz_r; bin_r <= bin_of(sz_r); end
      OP_FR_OK:   res_ok_r <= 1'b1;
      default: ;
    endcase
  end

  // status flags
  always_comb begin
    stat.mode = mode_r;
    stat.req_zero = (req_r == '0);
    stat.ready = ready_r;
    stat.free_bad = (addr_r == '0) || !ready_r || (addr_r < 16'(HDR));
    stat.cur_nil = (cur_r == NIL);
    stat.bin_last = (bin_r == LAST_BIN);
    stat.fit = (q_sz >= need_r);
    stat.p_end = (p_r >= HEAP_C) || (p_r > CW'(h_r));
    stat.p_hit = (p_r == CW'(h_r));
    stat.q_free = q[0];
    stat.split = (CW'(fsz_r) > CW'(need_r) + CW'(OVH));
    stat.right_in = (right_c < HEAP_C);
    stat.h_zero = (h_r == '0);
  end

  assign res_addr = res_addr_r;
  assign res_ok = res_ok_r;

endmodule
`default_nettype wire

>>> rtl/core/sfla_ctrl.sv
`default_nettype none
module sfla_ctrl
  import sfla_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire stat_t stat,
  output op_t        op,
  output logic       busy,
  output logic       done
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISP,
    S_SU0, S_SU1, S_SU2, S_SU3,
    S_NEED, S_HEAD, S_FF_CHK, S_FF_SIZE, S_FF_ADV,
    S_RM0, S_RM1, S_RM2, S_RM3, S_RM4, S_RM5,
    S_IN0, S_IN1, S_IN2,
    S_AL_SPLIT, S_SP0, S_SP1, S_SP2, S_SP3, S_AL_OK,
    S_WK0, S_WK1,
    S_RL0, S_RL1, S_RL_MRG, S_RL_FTR,
    S_LF0, S_LF1, S_LF2, S_LF_MRG, S_LF_FTR,
    S_FR_INS, S_FR_OK, S_DONE
  } st_t;

  st_t  state_r, state_nxt, ret_r, ret_nxt;
  logic busy_r, done_r;

  // next state, return point and micro-operation
  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    op = OP_NONE;
    unique case (state_r)
      S_IDLE: if (start) begin op = OP_LATCH; state_nxt = S_DISP; end
      S_DISP: begin
        if (!stat.mode) begin
          if (stat.req_zero) state_nxt = S_DONE;
          else if (!stat.ready) state_nxt = S_SU0;
          else state_nxt = S_NEED;
        end else if (stat.free_bad) begin
          state_nxt = S_DONE;
        end else begin
          op = OP_FR_INIT;
          state_nxt = S_WK0;
        end
      end
      S_SU0: begin op = OP_SETUP0; state_nxt = S_SU1; end
      S_SU1: begin op = OP_SETUP1; state_nxt = S_SU2; end
      S_SU2: begin op = OP_SETUP2; state_nxt = S_SU3; end
      S_SU3: begin op = OP_SETUP3; state_nxt = S_NEED; end
      S_NEED: begin op = OP_NEED; state_nxt = S_HEAD; end
      S_HEAD: begin op = OP_HEAD; state_nxt = S_FF_CHK; end
      S_FF_CHK: begin
        if (stat.cur_nil) begin
          if (stat.bin_last) state_nxt = S_DONE;
          else begin op = OP_NEXTBIN; state_nxt = S_HEAD; end
        end else begin
          op = OP_FF_RD;
          state_nxt = S_FF_SIZE;
        end
      end
      S_FF_SIZE: begin
        if (stat.fit) begin
          op = OP_FOUND;
          ret_nxt = S_AL_SPLIT;
          state_nxt = S_RM0;
        end else begin
          op = OP_FF_NX;
          state_nxt = S_FF_ADV;
        end
      end
      S_FF_ADV: begin op = OP_FF_ADV; state_nxt = S_FF_CHK; end
      // unlink a block from its bin
      S_RM0: begin op = OP_RM0; state_nxt = S_RM1; end
      S_RM1: begin op = OP_RM1; state_nxt = S_RM2; end
      S_RM2: begin op = OP_RM2; state_nxt = S_RM3; end
      S_RM3: begin op = OP_RM3; state_nxt = S_RM4; end
      S_RM4: begin op = OP_RM4; state_nxt = S_RM5; end
      S_RM5: begin op = OP_RM5; state_nxt = ret_r; end
      // push a block onto its bin
      S_IN0: begin op = OP_IN0; state_nxt = S_IN1; end
      S_IN1: begin op = OP_IN1; state_nxt = S_IN2; end
      S_IN2: begin op = OP_IN2; state_nxt = ret_r; end
      S_AL_SPLIT: begin
        if (stat.split) state_nxt = S_SP0;
        else begin op = OP_AL_WHOLE; state_nxt = S_AL_OK; end
      end
      S_SP0: begin op = OP_SP0; state_nxt = S_SP1; end
      S_SP1: begin op = OP_SP1; state_nxt = S_SP2; end
      S_SP2: begin op = OP_SP2; state_nxt = S_SP3; end
      S_SP3: begin op = OP_SP3; ret_nxt = S_AL_OK; state_nxt = S_IN0; end
      S_AL_OK: begin op = OP_AL_OK; state_nxt = S_DONE; end
      // walk the block chain to check the freed address
      S_WK0: begin
        if (stat.p_end) state_nxt = S_DONE;
        else begin op = OP_WK_RD; state_nxt = S_WK1; end
      end
      S_WK1: begin
        if (stat.p_hit) begin
          if (stat.q_free) state_nxt = S_DONE;
          else begin op = OP_WK_HIT; state_nxt = S_RL0; end
        end else begin
          op = OP_WK_ADV;
          state_nxt = S_WK0;
        end
      end
      // merge with the right neighbour
      S_RL0: begin
        if (stat.right_in) begin op = OP_RL_RD; state_nxt = S_RL1; end
        else begin op = OP_RL_MARK; state_nxt = S_LF0; end
      end
      S_RL1: begin
        if (stat.q_free) begin
          op = OP_RL_TAKE;
          ret_nxt = S_RL_MRG;
          state_nxt = S_RM0;
        end else begin
          op = OP_RL_MARK;
          state_nxt = S_LF0;
        end
      end
      S_RL_MRG: begin op = OP_RL_MRG; state_nxt = S_RL_FTR; end
      S_RL_FTR: begin op = OP_RL_FTR; state_nxt = S_LF0; end
      // merge with the left neighbour
      S_LF0: begin
        if (stat.h_zero) state_nxt = S_FR_INS;
        else begin op = OP_LF_RD; state_nxt = S_LF1; end
      end
      S_LF1: begin op = OP_LF_RD2; state_nxt = S_LF2; end
      S_LF2: begin
        if (stat.q_free) begin
          op = OP_LF_TAKE;
          ret_nxt = S_LF_MRG;
          state_nxt = S_RM0;
        end else begin
          state_nxt = S_FR_INS;
        end
      end
      S_LF_MRG: begin op = OP_LF_MRG; state_nxt = S_LF_FTR; end
      S_LF_FTR: begin op = OP_LF_FTR; state_nxt = S_FR_INS; end
      S_FR_INS: begin op = OP_FR_INS; ret_nxt = S_FR_OK; state_nxt = S_IN0; end
      S_FR_OK: begin op = OP_FR_OK; state_nxt = S_DONE; end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      busy_r <= (state_nxt != S_IDLE);
      done_r <= (state_nxt == S_DONE);
    end
  end

  assign busy = busy_r;
  assign done = done_r;

`ifndef SYNTHESIS
  a_done_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == S_DONE))
    else $error("result strobe outside the done state");
  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != S_IDLE))
    else $error("busy out of step with the controller state");
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after a result");
`endif

endmodule
`default_nettype wire

>>> rtl/core/segregated_free_list_allocator_unit.sv
`default_nettype none
// channel  | ports                                          | direction
// ---------+------------------------------------------------+----------
// command  | start, busy, in_mode, in_request_size,         | in
//          | in_block_address                               |
// result   | out_valid, out_payload_address, out_success    | out
//
// A command transfers when start is high and busy is low; one result follows.
// A zero size or a free rejected at dispatch goes straight to the result; an allocate may first
// set up the heap, passes free-list nodes and empty bins and may split; a free walks the blocks
// and merges neighbours, one heap access per step; busy drops in the cycle after the strobe.
// Reset clears the bin heads and the heap set-up flag; heap words stay unset.
// out_valid is high for one cycle and the receiver cannot stall it.
module segregated_free_list_allocator_unit
  import sfla_pkg::*;
#(
  parameter int HEAP_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_mode,
  input  wire logic [15:0] in_request_size,
  input  wire logic [15:0] in_block_address,
  output logic             out_valid,
  output logic [15:0]      out_payload_address,
  output logic             out_success
);

  op_t   op;
  stat_t stat;

  // sequencer
  sfla_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy),
    .done  (out_valid)
  );

  // heap memory, bins and working registers
  sfla_dp #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_mode          (in_mode),
    .in_request_size  (in_request_size),
    .in_block_address (in_block_address),
    .stat             (stat),
    .res_addr         (out_payload_address),
    .res_ok           (out_success)
  );

`ifndef SYNTHESIS
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");
  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_success) |-> (out_payload_address == 16'd0))
    else $error("failed result carries an address");
`endif

endmodule
`default_nettype wire

>>> test/tb_segregated_free_list_allocator_unit.sv
`default_nettype none
module tb_segregated_free_list_allocator_unit;
  import sfla_pkg::*;

  localparam int unsigned HEAP_SZ = 65536;
  localparam int unsigned WORDS = HEAP_SZ / 8;
  localparam int unsigned NO_LINK = 32'h1FFFF;
  localparam int unsigned BLK_LIMIT = HEAP_SZ / 32 + 1;
  localparam int unsigned STALL_LIMIT = 200000;
  localparam bit MODE_ALLOC = 1'b0;
  localparam bit MODE_FREE = 1'b1;

  typedef struct packed {
    logic [15:0] addr;
    logic        ok;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [15:0] in_request_size;
  logic [15:0] in_block_address;
  logic        out_valid;
  logic [15:0] out_payload_address;
  logic        out_success;

  // shadow heap state
  logic [16:0] heap_mem [WORDS];
  int unsigned free_head [12];
  bit          heap_set;

  grant_t      grant_q [$];
  int unsigned live_q [$];
  int unsigned dead_q [$];
  int          mismatches;
  int          idle_cycles;
  bit          no_gaps;

  segregated_free_list_allocator_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_request_size    (in_request_size),
    .in_block_address   (in_block_address),
    .out_valid          (out_valid),
    .out_payload_address(out_payload_address),
    .out_success        (out_success)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // heap word access, byte addressed
  function automatic int unsigned hp_rd(int unsigned b);
    return int'(heap_mem[(b >> 3) % WORDS]);
  endfunction

  function automatic void hp_wr(int unsigned b, int unsigned v);
    heap_mem[(b >> 3) % WORDS] = v[16:0];
  endfunction

  function automatic int unsigned blk_size(int unsigned h);
    return hp_rd(h) & ~32'd1;
  endfunction

  function automatic bit blk_free(int unsigned h);
    return ((hp_rd(h) & 32'd1) != 32'd0);
  endfunction

  function automatic int unsigned size_class(int unsigned s);
    if (s <= 128) return (s < 16) ? 0 : (s >> 4) - 1;
    if (s <= 256) return 8;
    if (s <= 512) return 9;
    if (s <= 1024) return 10;
    return 11;
  endfunction

  function automatic void link_in(int unsigned h);
    int unsigned c;
    int unsigned hd;
    c = size_class(blk_size(h));
    hd = free_head[c];
    hp_wr(h + 8, hd);
    hp_wr(h + 16, NO_LINK);
    if (hd != NO_LINK) hp_wr(hd + 16, h);
    free_head[c] = h;
  endfunction

  function automatic void unlink(int unsigned h);
    int unsigned c;
    int unsigned nx;
    int unsigned pv;
    c = size_class(blk_size(h));
    nx = hp_rd(h + 8);
    pv = hp_rd(h + 16);
    if (pv != NO_LINK) hp_wr(pv + 8, nx);
    else free_head[c] = nx;
    if (nx != NO_LINK) hp_wr(nx + 16, pv);
    hp_wr(h + 8, NO_LINK);
    hp_wr(h + 16, NO_LINK);
  endfunction

  function automatic int unsigned first_fit(int unsigned need);
    int unsigned cur;
    for (int unsigned c = size_class(need); c < 12; c++) begin
      cur = free_head[c];
      for (int unsigned n = 0; cur != NO_LINK && n < BLK_LIMIT; n++) begin
        if (blk_size(cur) >= need) return cur;
        cur = hp_rd(cur + 8);
      end
    end
    return NO_LINK;
  endfunction

  function automatic bit is_live_header(int unsigned h);
    int unsigned p;
    p = 0;
    for (int unsigned n = 0; p < HEAP_SZ && n < BLK_LIMIT; n++) begin
      if (p == h) return !blk_free(p);
      if (p > h) return 1'b0;
      p += blk_size(p) + HDR + FTR;
    end
    return 1'b0;
  endfunction

  // free with right then left coalescing
  function automatic void give_back(int unsigned h);
    int unsigned sz;
    int unsigned rt;
    int unsigned lt;
    sz = blk_size(h);
    rt = h + HDR + sz + FTR;
    if (rt < HEAP_SZ && blk_free(rt)) begin
      unlink(rt);
      sz = sz + HDR + blk_size(rt) + FTR;
      hp_wr(h, sz | 1);
      hp_wr(h + HDR + sz, h);
    end else begin
      hp_wr(h, sz | 1);
    end
    if (h > 0) begin
      lt = hp_rd(h - FTR);
      if (blk_free(lt)) begin
        unlink(lt);
        sz = blk_size(lt) + HDR + FTR + sz;
        hp_wr(lt, sz | 1);
        hp_wr(lt + HDR + sz, lt);
        h = lt;
      end
    end
    link_in(h);
  endfunction

  // expected result of one command, updating the shadow heap
  function automatic grant_t heap_command(bit m, int unsigned req, int unsigned a);
    grant_t g;
    int unsigned need;
    int unsigned h;
    int unsigned total;
    int unsigned rest;
    int unsigned nb;
    g = '0;
    if (m == MODE_ALLOC) begin
      if (req == 0) return g;
      if (!heap_set) begin
        hp_wr(0, (HEAP_SZ - HDR - FTR) | 1);
        hp_wr(HEAP_SZ - FTR, 0);
        link_in(0);
        heap_set = 1'b1;
      end
      need = (req + 15) & ~32'd15;
      h = first_fit(need);
      if (h == NO_LINK) return g;
      unlink(h);
      total = blk_size(h);
      if (total <= need + HDR + FTR) begin
        hp_wr(h, total);
      end else begin
        rest = total - need - HDR - FTR;
        nb = h + HDR + need + FTR;
        hp_wr(nb, rest | 1);
        hp_wr(h + HDR + need, h);
        hp_wr(nb + HDR + rest, nb);
        hp_wr(h, need);
        link_in(nb);
      end
      g.addr = 16'(h + HDR);
      g.ok = 1'b1;
      return g;
    end
    if (a == 0 || !heap_set || a < HDR) return g;
    if (!is_live_header(a - HDR)) return g;
    give_back(a - HDR);
    g.ok = 1'b1;
    return g;
  endfunction

  // one command transfer, with a random gap in front
  task automatic send_cmd(bit m, bit [15:0] req, bit [15:0] a);
    int gap;
    grant_t g;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_request_size <= req;
    in_block_address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = heap_command(m, req, a);
    grant_q.push_back(g);
    if (m == MODE_ALLOC && g.ok) live_q.push_back(g.addr);
    if (m == MODE_FREE && g.ok) begin
      foreach (live_q[i]) if (live_q[i] == a) begin
        live_q.delete(i);
        break;
      end
      dead_q.push_back(a);
    end
  endtask

  task automatic free_live_at(int idx);
    send_cmd(MODE_FREE, '0, 16'(live_q[idx]));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: addr=%0d ok=%0b", out_payload_address, out_success);
      end else begin
        if (out_payload_address !== grant_q[0].addr || out_success !== grant_q[0].ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr=%0d ok=%0b, got addr=%0d ok=%0b",
                     grant_q[0].addr, grant_q[0].ok, out_payload_address, out_success);
        end
        void'(grant_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no transfer either way
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** segregated_free_list_allocator_unit: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    int unsigned a0;
    int unsigned a1;
    int unsigned a2;
    send_cmd(MODE_FREE, '0, 16'd24);
    send_cmd(MODE_ALLOC, 16'd0, '0);
    send_cmd(MODE_FREE, '0, 16'd0);
    send_cmd(MODE_ALLOC, 16'd1, 16'hFFFF);
    send_cmd(MODE_ALLOC, 16'd16, '0);
    send_cmd(MODE_ALLOC, 16'd65535, '0);
    send_cmd(MODE_FREE, 16'hFFFF, 16'd23);
    send_cmd(MODE_ALLOC, 16'd128, '0);
    send_cmd(MODE_ALLOC, 16'd129, '0);
    send_cmd(MODE_ALLOC, 16'd256, '0);
    send_cmd(MODE_ALLOC, 16'd512, '0);
    send_cmd(MODE_ALLOC, 16'd1024, '0);
    send_cmd(MODE_ALLOC, 16'd1025, '0);
    a0 = live_q[1];
    a1 = live_q[2];
    a2 = live_q[3];
    // middle, a double free and a bad address, then both sides to merge left and right
    send_cmd(MODE_FREE, '0, 16'(a1));
    send_cmd(MODE_FREE, '0, 16'(a1));
    send_cmd(MODE_FREE, '0, 16'(a1 + 8));
    send_cmd(MODE_FREE, '0, 16'(a0));
    send_cmd(MODE_FREE, '0, 16'(a2));
    // reuse of the merged hole, split by both allocations
    send_cmd(MODE_ALLOC, 16'd40, '0);
    send_cmd(MODE_ALLOC, 16'd48, '0);
    while (live_q.size() > 0) free_live_at(0);
    send_cmd(MODE_ALLOC, 16'(HEAP_SZ - HDR - FTR), '0);
    send_cmd(MODE_FREE, '0, 16'(live_q[0]));
  endtask

  task automatic test_random_mix(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 55) send_cmd(MODE_ALLOC, 16'($urandom_range(1, 200)), 16'($urandom));
      else if (r < 60) send_cmd(MODE_ALLOC, 16'($urandom_range(200, 6000)), 16'($urandom));
      else if (r < 63) send_cmd(MODE_ALLOC, 16'($urandom), 16'($urandom));
      else if (r < 90 && live_q.size() > 0)
        free_live_at($urandom_range(0, live_q.size() - 1));
      else if (r < 95 && dead_q.size() > 0)
        send_cmd(MODE_FREE, 16'($urandom), 16'(dead_q[$urandom_range(0, dead_q.size() - 1)]));
      else send_cmd(MODE_FREE, 16'($urandom), 16'($urandom));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_cmd(MODE_ALLOC, 16'd32, '0);
    wait_drained();
    while (live_q.size() > 0) free_live_at($urandom_range(0, live_q.size() - 1));
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = 1'b0;
    in_request_size = '0;
    in_block_address = '0;
    mismatches = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    heap_set = 1'b0;
    foreach (heap_mem[i]) heap_mem[i] = '0;
    foreach (free_head[i]) free_head[i] = NO_LINK;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(200);
    test_drain_pause();
    test_random_mix(200);
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("** segregated_free_list_allocator_unit: PASSED **");
    end else begin
      $display("** segregated_free_list_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
